[rtl/core/cht_pkg.sv]
`default_nettype none
package cht_pkg;
   localparam int NodeCount = 1024;
   localparam int NodeBits = 10;
   localparam int SlotBits = 10;
   localparam int KeyBits = 32;
   localparam int ValBits = 32;
   localparam int CountBits = 11;
   localparam int PowerBits = 4;
   localparam int RecipBits = 28;
   localparam int RecipShift = 33;
   localparam int ProdBits = KeyBits + RecipBits;
   localparam int QuotBits = ProdBits - RecipShift;

   typedef enum logic [1:0] {
      REQ_STORE  = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_code_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MOD, S_HEAD, S_HEADWAIT, S_READ, S_READWAIT, S_CHECK,
      S_STORE, S_REMOVE, S_RESP
   } state_type;

   // controller commands to datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic mod_step;
      logic head_read;
      logic head_take;
      logic node_read;
      logic advance;
      logic take_value;
      logic do_store;
      logic do_remove;
      logic set_notfound;
      logic resp_load;
   } cmd_type;

   // datapath status to controller
   typedef struct packed {
      logic clear_done;
      logic mod_done;
      logic cur_null;
      logic key_hit;
      logic walk_limit;
   } stat_type;

   // prime for a clamped power, returned as 10 bits
   function automatic logic [9:0] prime_of(input logic [PowerBits-1:0] p);
      logic [9:0] r;
      case (p)
         4'd6: r = 10'd97;
         4'd7: r = 10'd193;
         4'd8: r = 10'd389;
         4'd9: r = 10'd769;
         default: r = 10'd53;
      endcase
      return r;
   endfunction

   // floor(2**33 / prime): quotient estimate is low by at most one
   function automatic logic [RecipBits-1:0] recip_of(input logic [PowerBits-1:0] p);
      logic [RecipBits-1:0] r;
      case (p)
         4'd6: r = 28'd88556026;
         4'd7: r = 28'd44507433;
         4'd8: r = 28'd22082094;
         4'd9: r = 28'd11170266;
         default: r = 28'd162074237;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

[rtl/core/cht_if.sv]
`default_nettype none
interface cht_req_if import cht_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] req_type;
   logic [KeyBits-1:0] key;
   logic [ValBits-1:0] store_value;
   modport source (output valid, req_type, key, store_value, input ready);
   modport sink (input valid, req_type, key, store_value, output ready);
endinterface

interface cht_rsp_if import cht_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [ValBits-1:0] value;
   logic [CountBits-1:0] entry_count;
   logic empty_res;
   modport source (output valid, status, value, entry_count, empty_res, input ready);
   modport sink (input valid, status, value, entry_count, empty_res, output ready);
endinterface

interface cht_csr_if import cht_pkg::*; ();
   logic valid;
   logic ready;
   logic [PowerBits-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/core/chained_hash_table.sv]
`default_nettype none
// each request runs the prime modulo (reciprocal multiply, quotient times prime,
// fix-up subtract), a bucket head read, then a store, or a chain walk for lookup and
// remove, before the response; the unused type skips both
// one request at a time: the next is taken only after the response is accepted
// reset: synchronous, active high; bucket heads then cleared in a pass over all slots,
// the same clearing follows every table_power write
module chained_hash_table import cht_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   cht_req_if.sink req,
   cht_rsp_if.source rsp,
   cht_csr_if.sink csr
);
   cmd_type cmd;
   stat_type stat;
   logic csr_fire;

   // register writes always taken
   assign csr.ready = 1'b1;
   assign csr_fire = csr.valid;

   cht_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_type(req.req_type),
      .rsp_ready(rsp.ready), .csr_fire(csr_fire), .stat(stat),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .cmd(cmd)
   );

   cht_dp u_dp (
      .clock(clock), .reset(reset),
      .csr_fire(csr_fire), .csr_data(csr.data), .cmd(cmd),
      .req_type(req.req_type), .req_key(req.key), .req_val(req.store_value),
      .stat(stat),
      .rsp_status(rsp.status), .rsp_value(rsp.value),
      .rsp_count(rsp.entry_count), .rsp_empty(rsp.empty_res)
   );
endmodule
`default_nettype wire

[rtl/core/cht_ctrl.sv]
`default_nettype none
module cht_ctrl import cht_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic [1:0] req_type,
   input  wire logic rsp_ready,
   input  wire logic csr_fire,
   input  stat_type stat,
   output logic req_ready,
   output logic rsp_valid,
   output cmd_type cmd
);
   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         op_ff <= REQ_NONE;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      if (csr_fire) begin
         state_in = S_CLEAR;
      end else begin
         unique case (state_ff)
            S_CLEAR: if (stat.clear_done) state_in = S_IDLE;
            S_IDLE: begin
               if (req_valid) begin
                  op_in = req_type;
                  state_in = S_MOD;
               end
            end
            S_MOD: if (stat.mod_done) state_in = S_HEAD;
            S_HEAD: state_in = S_HEADWAIT;
            S_HEADWAIT: begin
               if (op_ff == REQ_STORE) state_in = S_STORE;
               else if (op_ff == REQ_NONE) state_in = S_RESP;
               else state_in = S_READ;
            end
            S_READ: begin
               if (stat.cur_null || stat.walk_limit) state_in = S_RESP;
               else state_in = S_READWAIT;
            end
            S_READWAIT: state_in = S_CHECK;
            S_CHECK: begin
               if (stat.key_hit) state_in = (op_ff == REQ_REMOVE) ? S_REMOVE : S_RESP;
               else state_in = S_READ;
            end
            S_STORE: state_in = S_RESP;
            S_REMOVE: state_in = S_RESP;
            S_RESP: if (rsp_ready) state_in = S_IDLE;
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_CLEAR: cmd.clear_step = 1'b1;
         S_IDLE: begin
            req_ready = ~csr_fire;
            cmd.load_req = req_valid & ~csr_fire;
         end
         S_MOD: cmd.mod_step = 1'b1;
         S_HEAD: cmd.head_read = 1'b1;
         S_HEADWAIT: cmd.head_take = 1'b1;
         S_READ: begin
            cmd.node_read = ~(stat.cur_null | stat.walk_limit);
            cmd.set_notfound = stat.cur_null | stat.walk_limit;
         end
         S_CHECK: begin
            cmd.advance = ~stat.key_hit;
            cmd.take_value = stat.key_hit;
         end
         S_STORE: cmd.do_store = 1'b1;
         S_REMOVE: cmd.do_remove = 1'b1;
         S_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !csr_fire |=> rsp_valid) else $error("rsp dropped");
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("overlap");
   assert property (@(posedge clock) disable iff (reset)
      $past(csr_fire) |-> state_ff == S_CLEAR) else $error("no clear");
endmodule
`default_nettype wire

[rtl/core/cht_dp.sv]
`default_nettype none
module cht_dp import cht_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_fire,
   input  wire logic [PowerBits-1:0] csr_data,
   input  cmd_type cmd,
   input  wire logic [1:0] req_type,
   input  wire logic [KeyBits-1:0] req_key,
   input  wire logic [ValBits-1:0] req_val,
   output stat_type stat,
   output logic [1:0] rsp_status,
   output logic [ValBits-1:0] rsp_value,
   output logic [CountBits-1:0] rsp_count,
   output logic rsp_empty
);
   // memories: head store needs a clearing pass
   logic [NodeBits:0] head_mem [NodeCount];
   logic [KeyBits-1:0] key_mem [NodeCount];
   logic [ValBits-1:0] val_mem [NodeCount];
   logic [NodeBits:0] next_mem [NodeCount];

   logic [PowerBits-1:0] power_ff;
   logic [SlotBits:0] clr_ff;
   logic [1:0] op_ff;
   logic [KeyBits-1:0] key_ff;
   logic [ValBits-1:0] val_ff;
   logic [1:0] mstep_ff;
   logic [ProdBits-1:0] prod_ff;
   logic [QuotBits+9:0] qp_ff;
   logic [SlotBits-1:0] bucket_ff;
   logic [NodeBits:0] cur_ff, prev_ff, head_rd_ff, next_rd_ff, free_ff;
   logic [KeyBits-1:0] key_rd_ff;
   logic [ValBits-1:0] val_rd_ff;
   logic [NodeBits:0] fresh_ff;
   logic [CountBits-1:0] count_ff;
   logic [CountBits-1:0] steps_ff;
   logic [1:0] status_ff;
   logic [ValBits-1:0] value_ff;
   logic [NodeBits:0] new_node;
   logic have_node;
   logic [9:0] prime;
   logic [RecipBits-1:0] recip;
   logic [KeyBits-1:0] diff;
   logic [10:0] diff_lo;
   logic [10:0] diff_sub;

   assign prime = prime_of(power_ff);
   assign recip = recip_of(power_ff);
   // key mod prime: reciprocal multiply, quotient times prime, then one fix-up subtract
   assign diff = key_ff - qp_ff[KeyBits-1:0];
   assign diff_lo = diff[10:0];
   assign diff_sub = diff_lo - {1'b0, prime};

   assign stat.clear_done = clr_ff[SlotBits];
   assign stat.mod_done = mstep_ff[1];
   assign stat.cur_null = cur_ff[NodeBits];
   assign stat.key_hit = key_rd_ff == key_ff;
   assign stat.walk_limit = steps_ff[CountBits-1];

   assign have_node = ~free_ff[NodeBits] | ~fresh_ff[NodeBits];
   assign new_node = ~free_ff[NodeBits] ? free_ff : fresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff <= 4'd5;
         clr_ff <= '0;
         free_ff <= '1;
         fresh_ff <= '0;
         count_ff <= '0;
      end else if (csr_fire) begin
         power_ff <= (csr_data < 4'd5) ? 4'd5 : (csr_data > 4'd9) ? 4'd9 : csr_data;
         clr_ff <= '0;
         free_ff <= '1;
         fresh_ff <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.do_store && have_node) begin
            if (~free_ff[NodeBits]) free_ff <= next_rd_ff;
            else fresh_ff <= fresh_ff + 1'b1;
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.do_remove) begin
            free_ff <= cur_ff;
            if (count_ff != '0) count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) head_mem[clr_ff[SlotBits-1:0]] <= '1;
      head_rd_ff <= head_mem[bucket_ff];
      if (cmd.do_store && have_node) begin
         head_mem[bucket_ff] <= new_node;
      end else if (cmd.do_remove && prev_ff[NodeBits]) begin
         head_mem[bucket_ff] <= next_rd_ff;
      end
   end

   // free push writes node link in the cycle after the unlink
   logic push_ff;
   logic [NodeBits:0] push_node_ff, push_link_ff;
   always_ff @(posedge clock) begin
      if (reset) push_ff <= 1'b0;
      else push_ff <= cmd.do_remove;
   end

   // node port: read address is the free head in the head read (needed by store), else the current node
   logic [NodeBits-1:0] rd_addr;
   assign rd_addr = cmd.head_read ? free_ff[NodeBits-1:0] : cur_ff[NodeBits-1:0];
   always_ff @(posedge clock) begin
      if (cmd.head_read || cmd.node_read) begin
         key_rd_ff <= key_mem[rd_addr];
         val_rd_ff <= val_mem[rd_addr];
         next_rd_ff <= next_mem[rd_addr];
      end
      if (cmd.do_store && have_node) begin
         key_mem[new_node[NodeBits-1:0]] <= key_ff;
         val_mem[new_node[NodeBits-1:0]] <= val_ff;
      end
      if (cmd.do_store && have_node)
         next_mem[new_node[NodeBits-1:0]] <= head_rd_ff;
      else if (cmd.do_remove && ~prev_ff[NodeBits])
         next_mem[prev_ff[NodeBits-1:0]] <= next_rd_ff;
      else if (push_ff)
         next_mem[push_node_ff[NodeBits-1:0]] <= push_link_ff;
      push_node_ff <= cur_ff;
      push_link_ff <= free_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_type;
         key_ff <= req_key;
         val_ff <= req_val;
         mstep_ff <= '0;
         status_ff <= ST_OK;
         value_ff <= '0;
         steps_ff <= '0;
         prev_ff <= '1;
      end
      if (cmd.mod_step) begin
         mstep_ff <= mstep_ff + 1'b1;
         case (mstep_ff)
            2'd0: prod_ff <= {{RecipBits{1'b0}}, key_ff} * {{KeyBits{1'b0}}, recip};
            2'd1: qp_ff <= {10'd0, prod_ff[ProdBits-1:RecipShift]}
                           * {{QuotBits{1'b0}}, prime};
            2'd2: bucket_ff <= (diff_lo >= {1'b0, prime}) ? diff_sub[SlotBits-1:0]
                                                          : diff_lo[SlotBits-1:0];
            default: ;
         endcase
      end
      if (cmd.head_take) cur_ff <= head_rd_ff;
      if (cmd.node_read) steps_ff <= steps_ff + 1'b1;
      if (cmd.advance) begin
         prev_ff <= cur_ff;
         cur_ff <= next_rd_ff;
      end
      if (cmd.set_notfound) status_ff <= ST_NOTFOUND;
      if (cmd.do_store && !have_node) status_ff <= ST_FULL;
      if (cmd.take_value) value_ff <= val_rd_ff;
   end

   assign rsp_status = status_ff;
   assign rsp_value = (status_ff == ST_OK && op_ff != REQ_STORE && op_ff != REQ_NONE)
                      ? value_ff : '0;
   assign rsp_count = count_ff;
   assign rsp_empty = count_ff == '0;

   assert property (@(posedge clock) disable iff (reset)
      cmd.do_store |-> !cmd.do_remove) else $error("store and remove");
   assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= NodeCount) else $error("fresh overflow");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= NodeCount) else $error("count overflow");
endmodule
`default_nettype wire

[tb/chained_hash_table_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module chained_hash_table_tb import cht_pkg::*; ();

   logic clock;
   logic reset;

   cht_req_if req ();
   cht_rsp_if rsp ();
   cht_csr_if csr ();

   chained_hash_table dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   always #5 clock = ~clock;

   // one expected response per request
   typedef struct {
      logic [1:0] status;
      logic [ValBits-1:0] value;
      logic [CountBits-1:0] entry_count;
      logic empty_res;
   } reply_type;

   reply_type awaited_q[$];
   int fail_count = 0;
   int checked_count = 0;
   int sent_count = 0;
   int full_count = 0;
   int miss_count = 0;
   bit idle_on = 1'b1;
   int hold_cycles = 0;

   // shadow copy of the table, -1 marks an empty link
   int bucket_head[1024];
   logic [KeyBits-1:0] node_key[NodeCount];
   logic [ValBits-1:0] node_val[NodeCount];
   int node_next[NodeCount];
   int free_head;
   int fresh_used;
   int entry_total;
   int power;

   // keys recently stored, so lookups and removes often hit
   logic [KeyBits-1:0] live_keys[$];

   function automatic int prime_for(int p);
      int r;
      case (p)
         6: r = 97;
         7: r = 193;
         8: r = 389;
         9: r = 769;
         default: r = 53;
      endcase
      return r;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < 1024; i++) bucket_head[i] = -1;
      free_head = -1;
      fresh_used = 0;
      entry_total = 0;
   endfunction

   // compute the response of one request and update the shadow table
   function automatic reply_type hash_table_apply(logic [1:0] kind, logic [KeyBits-1:0] k,
                                                  logic [ValBits-1:0] v);
      reply_type r;
      logic [31:0] prime_w;
      int b;
      int n;
      int prev;
      int steps;
      prime_w = prime_for(power);
      b = int'(k % prime_w) % 1024;
      r.status = ST_OK;
      r.value = '0;
      if (kind == REQ_STORE) begin
         if (free_head >= 0) begin
            n = free_head;
            free_head = node_next[n];
         end else if (fresh_used < NodeCount) begin
            n = fresh_used;
            fresh_used++;
         end else begin
            n = -1;
            r.status = ST_FULL;
            full_count++;
         end
         if (n >= 0) begin
            node_key[n] = k;
            node_val[n] = v;
            node_next[n] = bucket_head[b];
            bucket_head[b] = n;
            entry_total++;
         end
      end else if (kind == REQ_LOOKUP || kind == REQ_REMOVE) begin
         prev = -1;
         n = bucket_head[b];
         steps = 0;
         while (n >= 0 && node_key[n] != k && steps < NodeCount) begin
            prev = n;
            n = node_next[n];
            steps++;
         end
         if (n < 0 || node_key[n] != k) begin
            r.status = ST_NOTFOUND;
            miss_count++;
         end else begin
            r.value = node_val[n];
            if (kind == REQ_REMOVE) begin
               if (prev >= 0) node_next[prev] = node_next[n];
               else bucket_head[b] = node_next[n];
               node_next[n] = free_head;
               free_head = n;
               if (entry_total > 0) entry_total--;
            end
         end
      end
      r.entry_count = entry_total[CountBits-1:0];
      r.empty_res = (entry_total == 0);
      return r;
   endfunction

   // after an occasional idle gap, offer one request, wait for the handshake, then record the expected response
   task automatic send_request(logic [1:0] kind, logic [KeyBits-1:0] k,
                               logic [ValBits-1:0] v);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.req_type <= kind;
      req.key <= k;
      req.store_value <= v;
      do @(posedge clock); while (!req.ready);
      awaited_q.push_back(hash_table_apply(kind, k, v));
      sent_count++;
      if (kind == REQ_STORE) begin
         live_keys.push_back(k);
         if (live_keys.size() > 300) void'(live_keys.pop_front());
      end
   endtask

   task automatic drain_responses();
      req.valid <= 1'b0;
      while (awaited_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // write table_power; only called with the block idle
   task automatic write_power(logic [PowerBits-1:0] p);
      drain_responses();
      csr.valid <= 1'b1;
      csr.data <= p;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      power = (p < 5) ? 5 : (p > 9) ? 9 : int'(p);
      wipe_table();
      live_keys.delete();
   endtask

   // result side: random ready stalls plus an occasional long hold
   initial begin
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      reply_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (awaited_q.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            e = awaited_q.pop_front();
            checked_count++;
            if (rsp.status !== e.status) begin
               $error("status expected %0d got %0d", e.status, rsp.status);
               fail_count++;
            end
            if (rsp.value !== e.value) begin
               $error("value expected %h got %h", e.value, rsp.value);
               fail_count++;
            end
            if (rsp.entry_count !== e.entry_count) begin
               $error("entry_count expected %0d got %0d", e.entry_count, rsp.entry_count);
               fail_count++;
            end
            if (rsp.empty_res !== e.empty_res) begin
               $error("empty_res expected %0d got %0d", e.empty_res, rsp.empty_res);
               fail_count++;
            end
         end
      end
   end

   // pick a key: mostly a live one, sometimes a colliding one, else random
   function automatic logic [KeyBits-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6 && live_keys.size() != 0)
         return live_keys[$urandom_range(0, live_keys.size() - 1)];
      if (sel < 8)
         return $urandom_range(0, 40) * prime_for(power) + $urandom_range(0, 3);
      return $urandom;
   endfunction

   // extremes of key and value, shadowing, chain middle removal, misses, unused type
   task automatic test_directed();
      logic [31:0] base;
      base = 32'd7;
      send_request(REQ_LOOKUP, 32'h0, 32'h0);
      send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_request(REQ_STORE, 32'h0, 32'hFFFF_FFFF);
      send_request(REQ_STORE, 32'hFFFF_FFFF, 32'h0);
      send_request(REQ_LOOKUP, 32'h0, 32'h1234_5678);
      send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      // duplicate key: newer entry shadows the older one
      send_request(REQ_STORE, 32'h0, 32'hA5A5_5A5A);
      send_request(REQ_LOOKUP, 32'h0, 32'h0);
      send_request(REQ_REMOVE, 32'h0, 32'h0);
      send_request(REQ_LOOKUP, 32'h0, 32'h0);
      // three keys in one bucket, remove the middle then the tail
      send_request(REQ_STORE, base, 32'h1111_1111);
      send_request(REQ_STORE, base + 53, 32'h2222_2222);
      send_request(REQ_STORE, base + 106, 32'h3333_3333);
      send_request(REQ_REMOVE, base + 53, 32'h0);
      send_request(REQ_LOOKUP, base, 32'h0);
      send_request(REQ_REMOVE, base, 32'h0);
      send_request(REQ_LOOKUP, base + 53, 32'h0);
      // unused request type reports state only
      send_request(REQ_NONE, base + 106, 32'hFFFF_FFFF);
      send_request(REQ_REMOVE, base + 106, 32'h0);
      send_request(REQ_REMOVE, 32'h0, 32'h0);
      send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_request(REQ_LOOKUP, 32'h0, 32'h0);
      drain_responses();
   endtask

   // exhaust the node pool, hit the full case, then recycle nodes via the free list
   task automatic test_pool_full();
      for (int i = 0; i < NodeCount + 2; i++) send_request(REQ_STORE, $urandom, $urandom);
      for (int i = 0; i < 8; i++) send_request(REQ_REMOVE, pick_key(), 32'h0);
      for (int i = 0; i < 10; i++) send_request(REQ_STORE, $urandom, $urandom);
      drain_responses();
   endtask

   // receiver holds off while requests keep coming, so the input backs up
   task automatic test_backpressure();
      hold_cycles = 600;
      for (int i = 0; i < 30; i++)
         send_request(logic'($urandom_range(0, 1)) ? REQ_STORE : REQ_LOOKUP, pick_key(),
                      $urandom);
      drain_responses();
   endtask

   task automatic test_random(int count);
      int r;
      logic [1:0] kind;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) kind = REQ_STORE;
         else if (r < 70) kind = REQ_LOOKUP;
         else if (r < 95) kind = REQ_REMOVE;
         else kind = REQ_NONE;
         send_request(kind, pick_key(), $urandom);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.req_type = REQ_STORE;
      req.key = '0;
      req.store_value = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      power = 5;
      wipe_table();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_pool_full();
      // out-of-range powers clamp; then walk the legal range, extremes included
      write_power(4'd0);
      test_backpressure();
      write_power(4'd9);
      test_random(150);
      write_power(4'd15);
      test_random(100);
      write_power(4'd6);
      test_random(150);
      write_power(4'd7);
      test_random(100);
      write_power(4'd8);
      test_random(100);
      write_power(4'd5);
      idle_on = 1'b0;
      test_random(100);

      drain_responses();
      $display("covered %0d requests over powers 5..9 incl. clamped writes", sent_count);
      $display("%0d responses checked, %0d pool-full, %0d misses",
               checked_count, full_count, miss_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
rtl/core/cht_pkg.sv
rtl/core/cht_if.sv
rtl/core/cht_ctrl.sv
rtl/core/cht_dp.sv
rtl/core/chained_hash_table.sv
tb/chained_hash_table_tb.sv
